### rtl/core/positional_list_engine_unit_macros.svh
// Assertion macros used by the checker file of the list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLEU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

### rtl/core/pleu_pkg.sv
package pleu_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int POS_W     = 8;
	localparam int VAL_W     = 32;
	localparam int LEN_W     = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic [POS_W-1:0]          position;
		logic signed [VAL_W-1:0]   value;
	} req_item_t;

	typedef struct packed {
		logic                      success;
		logic [LEN_W-1:0]          found_position;
		logic [LEN_W-1:0]          length;
	} rsp_item_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic ins;
		logic del;
		logic cmp;
		logic shr;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

### rtl/core/pleu_cell.sv
module pleu_cell #(
	parameter int IDX_W = $clog2(pleu_pkg::DEPTH_DEF),
	parameter int K     = 0
) (
	input  logic                               clk,
	input  pleu_pkg::cell_cmd_t                cmd,
	input  logic [IDX_W-1:0]                   idx,
	input  logic signed [pleu_pkg::VAL_W-1:0]  value,
	input  logic signed [pleu_pkg::VAL_W-1:0]  left_entry,
	input  logic signed [pleu_pkg::VAL_W-1:0]  right_entry,
	input  logic                               right_match,
	output logic signed [pleu_pkg::VAL_W-1:0]  entry,
	output logic                               match
);
	import pleu_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

	logic signed [VAL_W-1:0] entry_q;
	logic                    match_q;

	// Cells past the insert point take the entry of the lower neighbor; cells at or past
	// the delete point take the entry of the upper neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == idx) begin
				entry_q <= value;
			end else if (MY_IDX > idx) begin
				entry_q <= left_entry;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= idx) begin
				entry_q <= right_entry;
			end
		end
		if (cmd.cmp) begin
			match_q <= (entry_q == value);
		end else if (cmd.shr) begin
			match_q <= right_match;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

### rtl/core/pleu_ctrl.sv
module pleu_ctrl #(
	parameter int DEPTH = pleu_pkg::DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  pleu_pkg::req_item_t                req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output pleu_pkg::rsp_item_t                rsp,
	output pleu_pkg::cell_cmd_t                cmd,
	output logic [IDX_W-1:0]                   idx,
	output logic signed [pleu_pkg::VAL_W-1:0]  value,
	input  logic                               head_match
);
	import pleu_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	state_t             state_q, state_d;
	req_item_t          item_q;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   scan_q, scan_d;
	rsp_item_t          res_q, res_d;
	rsp_item_t          rsp_q;
	logic               rsp_valid_q;
	logic               rsp_load;
	logic               accept;
	logic [CMP_W-1:0]   pos_c;
	logic [CMP_W-1:0]   cnt_c;
	logic               ins_ok;
	logic               del_ok;

	assign pos_c  = CMP_W'(item_q.position);
	assign cnt_c  = CMP_W'(count_q);
	assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1))
		&& (count_q < CNT_W'(DEPTH));
	assign del_ok = (pos_c != '0) && (pos_c <= cnt_c);
	assign idx    = IDX_W'(pos_c - CMP_W'(1));
	assign value  = item_q.value;
	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= scan_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		res_q <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		scan_d    = scan_q;
		res_d     = res_q;
		cmd       = '0;
		rsp_load  = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				res_d   = '{success: 1'b0, found_position: '0, length: LEN_W'(count_q)};
				case (item_q.action)
					ACT_INSERT: begin
						if (ins_ok) begin
							cmd.ins      = 1'b1;
							count_d      = count_q + CNT_W'(1);
							res_d.success = 1'b1;
							res_d.length = LEN_W'(count_q + CNT_W'(1));
						end
					end
					ACT_DELETE: begin
						if (del_ok) begin
							cmd.del      = 1'b1;
							count_d      = count_q - CNT_W'(1);
							res_d.success = 1'b1;
							res_d.length = LEN_W'(count_q - CNT_W'(1));
						end
					end
					ACT_SEARCH: begin
						cmd.cmp = 1'b1;
						scan_d  = '0;
						state_d = ST_SCAN;
					end
					default: begin
						count_d       = '0;
						res_d.success = 1'b1;
						res_d.length  = '0;
					end
				endcase
			end
			ST_SCAN: begin
				if (scan_q == count_q) begin
					res_d   = '{success: 1'b0, found_position: '0,
						length: LEN_W'(count_q)};
					state_d = ST_DONE;
				end else if (head_match) begin
					res_d   = '{success: 1'b1, found_position: LEN_W'(scan_q + CNT_W'(1)),
						length: LEN_W'(count_q)};
					state_d = ST_DONE;
				end else begin
					cmd.shr = 1'b1;
					scan_d  = scan_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/positional_list_engine_unit.sv
// Channel   Signals                       Direction  Contents
// request   req_valid, req_ready, req     in         action, position, value
// response  rsp_valid, rsp_ready, rsp     out        success, found_position, length
//
// Insert, delete and clear pass through EXEC and DONE after acceptance before the next item
// can be taken; a search walks through SCAN between them and ends on a hit, or on a miss once
// every entry has been passed. The match flags move one cell per cycle toward the head of the chain.
// The asynchronous reset empties the list; the entry registers themselves are not cleared.
// A stalled response holds in its output register while the next item is taken in.
module positional_list_engine_unit #(
	parameter int DEPTH = pleu_pkg::DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pleu_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output pleu_pkg::rsp_item_t  rsp
);
	import pleu_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	// Every cell sees the same command, position index and operand value.
	cell_cmd_t               cmd;
	logic [IDX_W-1:0]        idx;
	logic signed [VAL_W-1:0] value;

	// Entry and match flag of each cell; the neighbors read them, and the controller reads the head match flag.
	logic signed [VAL_W-1:0] entry_w [DEPTH];
	logic                    match_w [DEPTH];

	// The controller owns the length, the handshakes and the search walk.
	pleu_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cmd        (cmd),
		.idx        (idx),
		.value      (value),
		.head_match (match_w[0])
	);

	// Cell k holds list position k+1. The first cell has no lower neighbor, the last has
	// no upper neighbor: it keeps its own entry on a delete and feeds a clear match flag.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [VAL_W-1:0] left_w;
		logic signed [VAL_W-1:0] right_w;
		logic                    right_m;

		if (k == 0) begin : g_head
			assign left_w = value;
		end else begin : g_body_l
			assign left_w = entry_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign right_w = entry_w[k];
			assign right_m = 1'b0;
		end else begin : g_body_r
			assign right_w = entry_w[k+1];
			assign right_m = match_w[k+1];
		end

		pleu_cell #(
			.IDX_W (IDX_W),
			.K     (k)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.idx         (idx),
			.value       (value),
			.left_entry  (left_w),
			.right_entry (right_w),
			.right_match (right_m),
			.entry       (entry_w[k]),
			.match       (match_w[k])
		);
	end

endmodule

### rtl/core/pleu_checker.sv
`include "positional_list_engine_unit_macros.svh"

module pleu_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input pleu_pkg::rsp_item_t  rsp
);
	import pleu_pkg::*;

	`PLEU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`PLEU_ASSERT_NOW(a_found_ok, clk, arst_n, rsp_valid && (rsp.found_position != '0), rsp.success)
	`PLEU_ASSERT_NOW(a_miss_zero, clk, arst_n, rsp_valid && !rsp.success, rsp.found_position == '0)
	`PLEU_ASSERT_NEXT(a_one_at_once, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind positional_list_engine_unit pleu_checker u_pleu_checker (.*);
